// File: hw/rtl/positional_ordered_list_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional ordered list.
// Each macro expects signals clk and arst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define POL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Types and codes shared by the positional ordered list and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

	localparam int IDX_W = 6;

	localparam logic [2:0] ACT_INS_FRONT = 3'd0;
	localparam logic [2:0] ACT_INS_BACK  = 3'd1;
	localparam logic [2:0] ACT_INS_AT    = 3'd2;
	localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
	localparam logic [2:0] ACT_DEL_BACK  = 3'd4;
	localparam logic [2:0] ACT_DEL_AT    = 3'd5;
	localparam logic [2:0] ACT_DUMP      = 3'd6;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_BADPOS = 2'd1;
	localparam logic [1:0] STAT_EMPTY  = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] last_idx;
	} cell_ctrl_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
		logic [4:0]         position;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic [4:0]         count;
		logic [1:0]         status;
		logic               last;
	} rsp_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell
// One list slot. It holds its entry, takes a new value, or takes the entry of
// its left or right neighbor or of the head cell as the broadcast control asks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pol_cell #(
	parameter int INDEX      = 0,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire pol_pkg::cell_ctrl_t    ctrl,
	input  wire logic [DATA_WIDTH-1:0]  value,
	input  wire logic [DATA_WIDTH-1:0]  left_data,
	input  wire logic [DATA_WIDTH-1:0]  right_data,
	input  wire logic [DATA_WIDTH-1:0]  head_data,
	output logic      [DATA_WIDTH-1:0]  data
);

	localparam logic [pol_pkg::IDX_W-1:0] MY_IDX = pol_pkg::IDX_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			pol_pkg::CELL_INSERT: begin
				if (MY_IDX == ctrl.idx) begin
					data_d = value;
				end else if (MY_IDX > ctrl.idx) begin
					data_d = left_data;
				end
			end
			pol_pkg::CELL_DELETE: begin
				if (MY_IDX >= ctrl.idx) begin
					data_d = right_data;
				end
			end
			pol_pkg::CELL_ROTATE: begin
				if (MY_IDX == ctrl.last_idx) begin
					data_d = head_data;
				end else begin
					data_d = right_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

// File: hw/rtl/positional_ordered_list.sv
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list held in a row of cells that shift as one.
// Insert, delete, any rejected command and an unused action code give one result item,
// presented in the output register the cycle after the command is taken.
// A dump of N entries rotates the row once per result, so its N results come
// at full output rate while the output is not stalled, and the next command is
// taken only once the last dump result has been loaded.
// Reset clears the occupancy and control state; cell contents are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "positional_ordered_list_macros.svh"

module positional_ordered_list #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire pol_pkg::cmd_item_t   cmd,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output pol_pkg::rsp_item_t        rsp
);

	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((OCC_W > 5) ? OCC_W : 5) + 1;
	localparam logic [CMP_W-1:0] CAP_W = CMP_W'(CAPACITY);

	pol_pkg::state_t    state_q;
	pol_pkg::state_t    state_d;
	logic [OCC_W-1:0]   occ_q;
	logic [OCC_W-1:0]   occ_d;
	logic [OCC_W-1:0]   cnt_q;
	logic               rsp_valid_q;
	pol_pkg::rsp_item_t rsp_q;

	logic                        out_free;
	logic                        cmd_fire;
	logic                        dump_run;
	logic                        dump_last;
	logic                        load_dump;
	logic [1:0]                  dec_status;
	pol_pkg::cell_op_t           dec_op;
	logic [CMP_W-1:0]            dec_idx;
	logic [CMP_W-1:0]            pos_w;
	logic [CMP_W-1:0]            occ_w;
	logic [CMP_W-1:0]            occ_d_w;
	logic [CMP_W-1:0]            last_w;
	pol_pkg::cell_ctrl_t         ctrl;
	logic [63:0]                 value_ext;
	logic [DATA_WIDTH-1:0]       value_st;
	logic [DATA_WIDTH-1:0]       cells [CAPACITY];
	logic signed [63:0]          head_ext;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == pol_pkg::ST_IDLE) && out_free;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign load_dump = (state_q == pol_pkg::ST_DUMP) && out_free;
	assign dump_last = (cnt_q == occ_q - OCC_W'(1));

	assign pos_w   = CMP_W'(cmd.position);
	assign occ_w   = CMP_W'(occ_q);
	assign occ_d_w = CMP_W'(occ_d);
	assign last_w  = occ_w - CMP_W'(1);

	assign value_ext = {32'b0, cmd.value};
	assign value_st  = value_ext[DATA_WIDTH-1:0];
	assign head_ext  = 64'(signed'(cells[0]));

	always_comb begin
		dec_status = pol_pkg::STAT_OK;
		dec_op     = pol_pkg::CELL_HOLD;
		dec_idx    = '0;
		occ_d      = occ_q;
		dump_run   = 1'b0;
		case (cmd.action)
			pol_pkg::ACT_INS_FRONT, pol_pkg::ACT_INS_BACK: begin
				if (occ_w >= CAP_W) begin
					dec_status = pol_pkg::STAT_FULL;
				end else begin
					dec_op  = pol_pkg::CELL_INSERT;
					dec_idx = (cmd.action == pol_pkg::ACT_INS_FRONT) ? '0 : occ_w;
					occ_d   = occ_q + OCC_W'(1);
				end
			end
			pol_pkg::ACT_INS_AT: begin
				if (pos_w == '0 || pos_w > occ_w + CMP_W'(1)) begin
					dec_status = pol_pkg::STAT_BADPOS;
				end else if (occ_w >= CAP_W) begin
					dec_status = pol_pkg::STAT_FULL;
				end else begin
					dec_op  = pol_pkg::CELL_INSERT;
					dec_idx = pos_w - CMP_W'(1);
					occ_d   = occ_q + OCC_W'(1);
				end
			end
			pol_pkg::ACT_DEL_FRONT, pol_pkg::ACT_DEL_BACK: begin
				if (occ_q == '0) begin
					dec_status = pol_pkg::STAT_EMPTY;
				end else begin
					dec_op  = pol_pkg::CELL_DELETE;
					dec_idx = (cmd.action == pol_pkg::ACT_DEL_FRONT) ? '0 : last_w;
					occ_d   = occ_q - OCC_W'(1);
				end
			end
			pol_pkg::ACT_DEL_AT: begin
				if (pos_w == '0 || pos_w > occ_w) begin
					dec_status = pol_pkg::STAT_BADPOS;
				end else begin
					dec_op  = pol_pkg::CELL_DELETE;
					dec_idx = pos_w - CMP_W'(1);
					occ_d   = occ_q - OCC_W'(1);
				end
			end
			pol_pkg::ACT_DUMP: begin
				if (occ_q == '0) begin
					dec_status = pol_pkg::STAT_EMPTY;
				end else begin
					dump_run = 1'b1;
				end
			end
			default: begin
				dec_status = pol_pkg::STAT_OK;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pol_pkg::ST_IDLE: begin
				if (cmd_fire && dump_run) begin
					state_d = pol_pkg::ST_DUMP;
				end
			end
			pol_pkg::ST_DUMP: begin
				if (out_free && dump_last) begin
					state_d = pol_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pol_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl.op       = pol_pkg::CELL_HOLD;
		ctrl.idx      = dec_idx[pol_pkg::IDX_W-1:0];
		ctrl.last_idx = last_w[pol_pkg::IDX_W-1:0];
		case (state_q)
			pol_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					ctrl.op = dec_op;
				end
			end
			pol_pkg::ST_DUMP: begin
				if (out_free) begin
					ctrl.op  = pol_pkg::CELL_ROTATE;
					ctrl.idx = '0;
				end
			end
			default: begin
				ctrl.op = pol_pkg::CELL_HOLD;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		pol_cell #(
			.INDEX      (i),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.value      (value_st),
			.left_data  ((i == 0) ? value_st : cells[(i == 0) ? 0 : i - 1]),
			.right_data ((i == CAPACITY - 1) ? cells[0]
				: cells[(i == CAPACITY - 1) ? 0 : i + 1]),
			.head_data  (cells[0]),
			.data       (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pol_pkg::ST_IDLE;
			occ_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_fire) begin
				occ_q <= occ_d;
				cnt_q <= '0;
			end else if (load_dump) begin
				cnt_q <= cnt_q + OCC_W'(1);
			end
			if ((cmd_fire && !dump_run) || load_dump) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_dump) begin
			rsp_q.element <= head_ext[31:0];
			rsp_q.count   <= occ_w[4:0];
			rsp_q.status  <= pol_pkg::STAT_OK;
			rsp_q.last    <= dump_last;
		end else if (cmd_fire && !dump_run) begin
			rsp_q.element <= '0;
			rsp_q.count   <= occ_d_w[4:0];
			rsp_q.status  <= dec_status;
			rsp_q.last    <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`POL_ASSERT_NOW(a_occ_bound, 1'b1, occ_w <= CAP_W, "occupancy above capacity")
	`POL_ASSERT_NOW(a_dump_blocks, state_q == pol_pkg::ST_DUMP, !cmd_ready,
		"command taken during a dump")
	`POL_ASSERT_NEXT(a_del_front, cmd_fire && cmd.action == pol_pkg::ACT_DEL_FRONT && occ_q != '0,
		occ_q == $past(occ_q) - OCC_W'(1), "delete did not lower occupancy")
	`POL_ASSERT_NOW(a_dump_nonempty, state_q == pol_pkg::ST_DUMP, occ_q != '0,
		"dump running on an empty list")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for positional_ordered_list
// Drives list commands through the valid/ready command channel and checks
// every response item against a shadow copy of the list kept in the bench.
// The shadow copy tracks the entries and the occupancy, and it queues the
// status, count and dumped elements that each accepted command must produce.
// A short directed run covers the empty, full and bad position cases. Random
// traffic grows and shrinks the list; two phases gap both channels randomly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 59;
	localparam logic [2:0] ACT_SPARE = 3'd7;

	class list_shadow;
		logic signed [31:0] held[$];
		pol_pkg::rsp_item_t due[$];
		int faults = 0;

		function void queue_rsp(logic signed [31:0] elem, logic [1:0] stat, logic fin);
			pol_pkg::rsp_item_t r;
			r.element = elem;
			r.count = 5'(held.size());
			r.status = stat;
			r.last = fin;
			due.push_back(r);
		endfunction

		function void apply_command(pol_pkg::cmd_item_t c);
			int n;
			logic [1:0] stat;
			n = held.size();
			stat = pol_pkg::STAT_OK;
			case (c.action)
				pol_pkg::ACT_INS_FRONT, pol_pkg::ACT_INS_BACK: begin
					if (n >= DEPTH)
						stat = pol_pkg::STAT_FULL;
					else if (c.action == pol_pkg::ACT_INS_FRONT)
						held.push_front(c.value);
					else
						held.push_back(c.value);
				end
				pol_pkg::ACT_INS_AT: begin
					if (c.position == 0 || int'(c.position) > n + 1)
						stat = pol_pkg::STAT_BADPOS;
					else if (n >= DEPTH)
						stat = pol_pkg::STAT_FULL;
					else
						held.insert(int'(c.position) - 1, c.value);
				end
				pol_pkg::ACT_DEL_FRONT, pol_pkg::ACT_DEL_BACK: begin
					if (n == 0)
						stat = pol_pkg::STAT_EMPTY;
					else if (c.action == pol_pkg::ACT_DEL_FRONT)
						void'(held.pop_front());
					else
						void'(held.pop_back());
				end
				pol_pkg::ACT_DEL_AT: begin
					if (c.position == 0 || int'(c.position) > n)
						stat = pol_pkg::STAT_BADPOS;
					else
						held.delete(int'(c.position) - 1);
				end
				pol_pkg::ACT_DUMP: begin
					if (n == 0) begin
						stat = pol_pkg::STAT_EMPTY;
					end else begin
						for (int i = 0; i < n; i++)
							queue_rsp(held[i], pol_pkg::STAT_OK, i == n - 1);
						return;
					end
				end
				default: begin
				end
			endcase
			queue_rsp('0, stat, 1'b1);
		endfunction

		function void check_response(pol_pkg::rsp_item_t got);
			pol_pkg::rsp_item_t want;
			if (due.size() == 0) begin
				$display("%0t: unexpected item: element %0d count %0d status %0d last %0d",
					$time, got.element, got.count, got.status, got.last);
				faults++;
				return;
			end
			want = due.pop_front();
			if (got.element !== want.element) begin
				$display("%0t: element expected %0d actual %0d", $time, want.element, got.element);
				faults++;
			end
			if (got.count !== want.count) begin
				$display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
				faults++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				faults++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
				faults++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	pol_pkg::cmd_item_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	pol_pkg::rsp_item_t rsp;

	int tx_gap_pct = 26;
	int rx_gap_pct = 60;
	bit growing = 1'b1;
	list_shadow shadow;

	positional_ordered_list DUT (clk, arst_n, cmd_valid, cmd_ready, cmd, rsp_valid, rsp_ready, rsp);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rx_gap_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			shadow.check_response(rsp);
		if (arst_n && cmd_valid && cmd_ready)
			shadow.apply_command(cmd);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send(input logic [2:0] act, input logic signed [31:0] val,
			input logic [4:0] pos);
		while ($urandom_range(99) < tx_gap_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd = '{action: act, value: val, position: pos};
		cmd_valid = 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		cmd_valid = 1'b0;
		while (shadow.due.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_phase(input int items);
		logic [2:0] act;
		logic signed [31:0] val;
		logic [4:0] pos;
		int n;
		int pick;
		for (int k = 0; k < items; k++) begin
			n = shadow.held.size();
			pick = $urandom_range(99);
			val = $urandom;
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0: val = 32'sh8000_0000;
					1: val = 32'sh7fff_ffff;
					2: val = '0;
					default: val = '1;
				endcase
			end
			pos = 5'($urandom_range(17));
			if (pick < 8) begin
				act = 3'($urandom_range(7));
			end else if (pick < 20) begin
				act = pol_pkg::ACT_DUMP;
			end else if (growing) begin
				act = pol_pkg::ACT_INS_FRONT + 3'($urandom_range(2));
				pos = 5'($urandom_range(n + 1, 1));
			end else begin
				act = pol_pkg::ACT_DEL_FRONT + 3'($urandom_range(2));
				if (n > 0)
					pos = 5'($urandom_range(n, 1));
			end
			send(act, val, pos);
			n = shadow.held.size();
			if ((growing && n == DEPTH && $urandom_range(2) == 0)
					|| (!growing && n == 0 && $urandom_range(2) == 0)
					|| $urandom_range(24) == 0)
				growing = !growing;
		end
	endtask

	initial begin
		shadow = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(pol_pkg::ACT_DUMP, 0, 0);
		send(pol_pkg::ACT_DEL_FRONT, 0, 0);
		send(pol_pkg::ACT_DEL_BACK, 0, 0);
		send(pol_pkg::ACT_DEL_AT, 0, 1);
		send(pol_pkg::ACT_INS_AT, 5, 0);
		send(ACT_SPARE, -1, 17);
		send(pol_pkg::ACT_INS_FRONT, 32'sh8000_0000, 0);
		send(pol_pkg::ACT_INS_BACK, 32'sh7fff_ffff, 0);
		send(pol_pkg::ACT_INS_AT, -1, 2);
		send(pol_pkg::ACT_INS_AT, 32'sh5555_5555, 5);
		send(pol_pkg::ACT_DEL_AT, 0, 0);
		send(pol_pkg::ACT_DEL_AT, 0, 2);
		send(pol_pkg::ACT_DUMP, 0, 0);
		while (shadow.held.size() < DEPTH)
			send(pol_pkg::ACT_INS_AT, $urandom, 5'($urandom_range(shadow.held.size() + 1, 1)));
		send(pol_pkg::ACT_INS_FRONT, 32'shaaaa_aaaa, 0);
		send(pol_pkg::ACT_INS_AT, 1, 17);
		send(pol_pkg::ACT_DEL_AT, 0, 17);
		send(pol_pkg::ACT_DUMP, 0, 0);
		send(pol_pkg::ACT_DEL_AT, 0, 16);
		send(pol_pkg::ACT_DEL_BACK, 0, 0);

		random_phase(PHASE_ITEMS);
		drain();
		tx_gap_pct = 60;
		rx_gap_pct = 26;
		random_phase(PHASE_ITEMS);
		drain();
		tx_gap_pct = 0;
		rx_gap_pct = 0;
		random_phase(PHASE_ITEMS);
		drain();
		repeat (20) @(posedge clk);

		if (shadow.faults == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
